FILE: hdl/random_walk_fading_trail_top_assert.svh
// Assertion macros shared by the fading trail RTL.
`ifndef RANDOM_WALK_FADING_TRAIL_TOP_ASSERT_SVH
`define RANDOM_WALK_FADING_TRAIL_TOP_ASSERT_SVH

// cond must never hold outside reset
`define RWFT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

// a implies b in the same cycle
`define RWFT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication failed");

// a implies b in the next cycle
`define RWFT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle implication failed");

`endif

FILE: hdl/rwft_pkg.sv
// Package for the fading trail block: types, constants, palette.
package rwft_pkg;

    localparam int GRID_COLS_DEF    = 8;
    localparam int GRID_ROWS_DEF    = 8;
    localparam int WALKER_SLOTS_DEF = 8;

    localparam int FULL_LEVEL  = 256;
    localparam int LEVEL_FLOOR = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] FADE_RATE_RST      = 9'd26;
    localparam logic [8:0] MOVE_RATE_RST      = 9'd64;
    localparam logic [3:0] ACTIVE_WALKERS_RST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_RATE      = 2'd0,
        CFG_MOVE_RATE      = 2'd1,
        CFG_ACTIVE_WALKERS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIR_X_INC = 2'd0,
        DIR_X_DEC = 2'd1,
        DIR_Y_INC = 2'd2,
        DIR_Y_DEC = 2'd3
    } dir_t;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] directions;
        logic [2:0]  walker_index;
        logic [2:0]  place_x;
        logic [2:0]  place_y;
    } in_t;

    typedef struct packed {
        logic [2:0] pixel_x;
        logic [2:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } out_t;

    typedef struct packed {
        logic accept;
        logic place;
        logic fade;
        logic move;
        logic stamp;
        logic emit_rd;
        logic emit_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic cell_last;
        logic walker_last;
        logic out_free;
        logic rd_last;
    } dp_status_t;

    function automatic logic [23:0] palette_colour(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0, 3'd5: c = 24'hFF0000;
            3'd1, 3'd6: c = 24'h00FF00;
            3'd2, 3'd7: c = 24'h0000FF;
            3'd3:       c = 24'hFFFF00;
            3'd4:       c = 24'hFF00FF;
            default:    c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/random_walk_fading_trail_top.sv
// Top level of the random walk fading trail block.
// Input channel s_valid/s_ready/s_data carries place and frame requests.
// A place request sets one walker's cell and emits nothing.
// A frame request fades all cells (one cell a cycle, the last write overlapping
// the first move cycle), steps each walker slot, stamps each slot, then emits
// COLS*ROWS pixels on m_valid/m_ready/m_data, x outer, y inner, last set on the
// final pixel. m_valid rises only after the stamp pass, and the next request is
// taken only once the last pixel is loaded into the output register; the cell
// memory's single read port reads one cell per cycle in the fade pass and, with
// no receiver stall, in the emit pass.
// s_ready is high only between requests; a result waiting in the output
// register does not block the next request.
// A receiver stall holds the current pixel and pauses the emit pass.
// cfg_wr_en/cfg_index/cfg_data write fade_rate, move_rate, active_walkers.
// Reset (aresetn low, synchronous) clears walkers, config and cell valid bits
// at once; no clearing pass is needed.
module random_walk_fading_trail_top #(
    parameter int GRID_COLS    = rwft_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS    = rwft_pkg::GRID_ROWS_DEF,
    parameter int WALKER_SLOTS = rwft_pkg::WALKER_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rwft_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rwft_pkg::out_t                   m_data,
    input  logic                             cfg_wr_en,
    input  logic [rwft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwft_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rwft_pkg::dp_cmd_t    cmd;
    rwft_pkg::dp_status_t status;

    rwft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rwft_dp #(
        .GRID_COLS    (GRID_COLS),
        .GRID_ROWS    (GRID_ROWS),
        .WALKER_SLOTS (WALKER_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

FILE: hdl/rwft_ctrl.sv
// Frame sequencer: fade pass, walker move, stamp, pixel emit.
module rwft_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_op,
    output logic                   s_ready,
    input  rwft_pkg::dp_status_t   status,
    output rwft_pkg::dp_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FADE    = 6'b000010,
        ST_MOVE    = 6'b000100,
        ST_STAMP   = 6'b001000,
        ST_EMIT_RD = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_op == rwft_pkg::OP_PLACE) begin
                        cmd.place = 1'b1;
                    end else begin
                        state_next = ST_FADE;
                    end
                end
            end
            ST_FADE: begin
                cmd.fade = 1'b1;
                if (status.cell_last) state_next = ST_MOVE;
            end
            ST_MOVE: begin
                cmd.move = 1'b1;
                if (status.walker_last) state_next = ST_STAMP;
            end
            ST_STAMP: begin
                cmd.stamp = 1'b1;
                if (status.walker_last) state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_ld = 1'b1;
                    if (status.rd_last) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/rwft_dp.sv
// Datapath: config registers, walker registers, cell memories, pixel output.
`include "random_walk_fading_trail_top_assert.svh"

module rwft_dp #(
    parameter int GRID_COLS    = rwft_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS    = rwft_pkg::GRID_ROWS_DEF,
    parameter int WALKER_SLOTS = rwft_pkg::WALKER_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rwft_pkg::dp_cmd_t                 cmd,
    output rwft_pkg::dp_status_t              status,
    input  rwft_pkg::in_t                     s_data,
    input  logic                              cfg_wr_en,
    input  logic [rwft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rwft_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output rwft_pkg::out_t                    m_data
);

    localparam int CELLS   = GRID_COLS * GRID_ROWS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int COL_W   = $clog2(GRID_COLS);
    localparam int ROW_W   = $clog2(GRID_ROWS);
    localparam int WK_W    = (WALKER_SLOTS > 1) ? $clog2(WALKER_SLOTS) : 1;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(GRID_ROWS - 1);
    localparam logic [WK_W-1:0]  WK_MAX  = WK_W'(WALKER_SLOTS - 1);

    // configuration
    logic [8:0] fade_rate_reg, move_rate_reg;
    logic [3:0] active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_rate_reg <= rwft_pkg::FADE_RATE_RST;
            move_rate_reg <= rwft_pkg::MOVE_RATE_RST;
            active_reg    <= rwft_pkg::ACTIVE_WALKERS_RST;
        end else if (cfg_wr_en) begin
            case (rwft_pkg::cfg_idx_t'(cfg_index))
                rwft_pkg::CFG_FADE_RATE:      fade_rate_reg <= cfg_data[8:0];
                rwft_pkg::CFG_MOVE_RATE:      move_rate_reg <= cfg_data[8:0];
                rwft_pkg::CFG_ACTIVE_WALKERS: active_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [8:0] keep;
    assign keep = (fade_rate_reg > 9'(rwft_pkg::FULL_LEVEL)) ? 9'd0
                : 9'(rwft_pkg::FULL_LEVEL) - fade_rate_reg;

    // cell scan counter, y inner
    logic [COL_W-1:0] x_reg;
    logic [ROW_W-1:0] y_reg;
    logic             cell_last, mem_re, rd_last_reg;

    assign cell_last = (x_reg == COL_MAX) && (y_reg == ROW_MAX);
    assign mem_re    = cmd.fade || cmd.emit_rd || (cmd.emit_ld && !rd_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else if (mem_re) begin
            if (y_reg == ROW_MAX) begin
                y_reg <= '0;
                x_reg <= (x_reg == COL_MAX) ? '0 : x_reg + 1'b1;
            end else begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

    logic [CELL_AW-1:0] raddr;
    assign raddr = CELL_AW'(int'(x_reg) * GRID_ROWS + int'(y_reg));

    // walkers
    logic [COL_W-1:0] col_reg   [WALKER_SLOTS];
    logic [ROW_W-1:0] row_reg   [WALKER_SLOTS];
    logic [8:0]       timer_reg [WALKER_SLOTS];
    logic [WK_W-1:0]  wcnt_reg;
    logic [15:0]      dirs_reg;

    logic [COL_W-1:0] cur_col, place_col;
    logic [ROW_W-1:0] cur_row, place_row;
    logic [9:0]       tsum;
    logic [1:0]       dir;
    logic             w_active, walker_last, place_ok;

    assign cur_col     = col_reg[wcnt_reg];
    assign cur_row     = row_reg[wcnt_reg];
    assign tsum        = {1'b0, timer_reg[wcnt_reg]} + {1'b0, move_rate_reg};
    assign dir         = dirs_reg[2 * int'(wcnt_reg) +: 2];
    assign w_active    = 4'(wcnt_reg) < active_reg;
    assign walker_last = (wcnt_reg == WK_MAX);
    assign place_ok    = 4'(s_data.walker_index) < 4'(WALKER_SLOTS);
    assign place_col   = (s_data.place_x > 3'(GRID_COLS - 1)) ? COL_MAX
                       : COL_W'(s_data.place_x);
    assign place_row   = (s_data.place_y > 3'(GRID_ROWS - 1)) ? ROW_MAX
                       : ROW_W'(s_data.place_y);

    always_ff @(posedge aclk) begin
        if (cmd.accept) dirs_reg <= s_data.directions;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg <= '0;
        end else if (cmd.move || cmd.stamp) begin
            wcnt_reg <= walker_last ? '0 : wcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WALKER_SLOTS; i++) begin
                col_reg[i]   <= '0;
                row_reg[i]   <= '0;
                timer_reg[i] <= '0;
            end
        end else if (cmd.place && place_ok) begin
            col_reg[WK_W'(s_data.walker_index)] <= place_col;
            row_reg[WK_W'(s_data.walker_index)] <= place_row;
        end else if (cmd.move && w_active) begin
            if (tsum >= 10'(rwft_pkg::FULL_LEVEL)) begin
                timer_reg[wcnt_reg] <= '0;
                case (rwft_pkg::dir_t'(dir))
                    rwft_pkg::DIR_X_INC:
                        if (cur_col != COL_MAX) col_reg[wcnt_reg] <= cur_col + 1'b1;
                    rwft_pkg::DIR_X_DEC:
                        if (cur_col != '0) col_reg[wcnt_reg] <= cur_col - 1'b1;
                    rwft_pkg::DIR_Y_INC:
                        if (cur_row != ROW_MAX) row_reg[wcnt_reg] <= cur_row + 1'b1;
                    rwft_pkg::DIR_Y_DEC:
                        if (cur_row != '0) row_reg[wcnt_reg] <= cur_row - 1'b1;
                    default: ;
                endcase
            end else begin
                timer_reg[wcnt_reg] <= tsum[8:0];
            end
        end
    end

    // cell memories with per-entry valid bits
    logic [8:0]  level_mem  [CELLS];
    logic [23:0] colour_mem [CELLS];
    logic [CELLS-1:0] level_vld_reg, colour_vld_reg;

    logic [8:0]         rd_level_raw_reg;
    logic [23:0]        rd_colour_raw_reg;
    logic               rd_lvl_vld_reg, rd_col_vld_reg;
    logic [COL_W-1:0]   rd_x_reg;
    logic [ROW_W-1:0]   rd_y_reg;
    logic               fade_wr_reg;
    logic [CELL_AW-1:0] fade_waddr_reg;

    logic [8:0]         rd_level, faded, wlevel;
    logic [23:0]        rd_colour;
    logic [17:0]        fade_prod;
    logic               stamp_en, lvl_we;
    logic [CELL_AW-1:0] stamp_addr, waddr;

    assign rd_level   = rd_lvl_vld_reg ? rd_level_raw_reg : '0;
    assign rd_colour  = rd_col_vld_reg ? rd_colour_raw_reg : '0;
    assign fade_prod  = {9'd0, rd_level} * {9'd0, keep};
    assign faded      = (fade_prod[16:8] < 9'(rwft_pkg::LEVEL_FLOOR)) ? 9'd0
                      : fade_prod[16:8];
    assign stamp_en   = cmd.stamp && w_active;
    assign stamp_addr = CELL_AW'(int'(cur_col) * GRID_ROWS + int'(cur_row));
    assign waddr      = fade_wr_reg ? fade_waddr_reg : stamp_addr;
    assign wlevel     = fade_wr_reg ? faded : 9'(rwft_pkg::FULL_LEVEL);
    assign lvl_we     = fade_wr_reg || stamp_en;

    always_ff @(posedge aclk) begin
        if (lvl_we) level_mem[waddr] <= wlevel;
        if (stamp_en) colour_mem[waddr] <= rwft_pkg::palette_colour(3'(wcnt_reg));
        if (mem_re) begin
            rd_level_raw_reg  <= level_mem[raddr];
            rd_colour_raw_reg <= colour_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_lvl_vld_reg <= level_vld_reg[raddr];
            rd_col_vld_reg <= colour_vld_reg[raddr];
            rd_x_reg       <= x_reg;
            rd_y_reg       <= y_reg;
        end
        fade_waddr_reg <= raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_vld_reg  <= '0;
            colour_vld_reg <= '0;
            fade_wr_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
        end else begin
            fade_wr_reg <= cmd.fade;
            if (mem_re) rd_last_reg <= cell_last;
            if (lvl_we) level_vld_reg[waddr] <= 1'b1;
            if (stamp_en) colour_vld_reg[waddr] <= 1'b1;
        end
    end

    // output register
    logic           m_valid_reg;
    rwft_pkg::out_t m_data_reg;
    logic [16:0]    red_prod, green_prod, blue_prod;
    logic           out_free;

    assign out_free   = !m_valid_reg || m_ready;
    assign red_prod   = {9'd0, rd_colour[23:16]} * {8'd0, rd_level};
    assign green_prod = {9'd0, rd_colour[15:8]} * {8'd0, rd_level};
    assign blue_prod  = {9'd0, rd_colour[7:0]} * {8'd0, rd_level};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_ld) begin
            m_data_reg.pixel_x <= 3'(rd_x_reg);
            m_data_reg.pixel_y <= 3'(rd_y_reg);
            m_data_reg.red     <= red_prod[15:8];
            m_data_reg.green   <= green_prod[15:8];
            m_data_reg.blue    <= blue_prod[15:8];
            m_data_reg.last    <= rd_last_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;
    assign status.cell_last   = cell_last;
    assign status.walker_last = walker_last;
    assign status.out_free    = out_free;
    assign status.rd_last     = rd_last_reg;

    `RWFT_ASSERT_NEVER(a_write_clash, aclk, aresetn, fade_wr_reg && cmd.stamp)
    `RWFT_ASSERT_IMPLY(a_load_when_free, aclk, aresetn, cmd.emit_ld, out_free)
    `RWFT_ASSERT_NEXT(a_last_pixel, aclk, aresetn, cmd.emit_ld && rd_last_reg, m_valid_reg && m_data_reg.last)

endmodule

FILE: dv/random_walk_fading_trail_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the fading trail grid: predicts every emitted pixel per frame request.
module random_walk_fading_trail_top_test;

    localparam int COLS          = rwft_pkg::GRID_COLS_DEF;
    localparam int ROWS          = rwft_pkg::GRID_ROWS_DEF;
    localparam int SLOTS         = rwft_pkg::WALKER_SLOTS_DEF;
    localparam int CELLS         = COLS * ROWS;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 2500;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 25;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    rwft_pkg::in_t                   s_data = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    rwft_pkg::out_t                  m_data;
    logic                            cfg_wr_en = 1'b0;
    logic [rwft_pkg::CFG_IDX_W-1:0]  cfg_index = rwft_pkg::CFG_FADE_RATE;
    logic [rwft_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rwft_pkg::in_t  req_backlog[$];
    rwft_pkg::out_t pixel_due[$];
    logic req_taken = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   mismatches = 0;

    // shadow of the block's registers and grid state
    logic [8:0]  fade_q = rwft_pkg::FADE_RATE_RST;
    logic [8:0]  move_q = rwft_pkg::MOVE_RATE_RST;
    logic [3:0]  walkers_q = rwft_pkg::ACTIVE_WALKERS_RST;
    logic [2:0]  walk_col [SLOTS] = '{default: '0};
    logic [2:0]  walk_row [SLOTS] = '{default: '0};
    logic [8:0]  walk_timer [SLOTS] = '{default: '0};
    logic [8:0]  cell_lvl [CELLS] = '{default: '0};
    logic [23:0] cell_rgb [CELLS] = '{default: '0};

    random_walk_fading_trail_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic trail_step(input rwft_pkg::in_t req);
        int             keep;
        int             lv;
        int             t;
        int             cnt;
        int             cell_idx;
        rwft_pkg::dir_t dir;
        rwft_pkg::out_t px;
        if (req.op == rwft_pkg::OP_PLACE) begin
            walk_col[req.walker_index] = req.place_x;
            walk_row[req.walker_index] = req.place_y;
            return;
        end
        keep = rwft_pkg::FULL_LEVEL - ((fade_q > rwft_pkg::FULL_LEVEL) ? rwft_pkg::FULL_LEVEL
                                                                       : int'(fade_q));
        for (int c = 0; c < CELLS; c++) begin
            lv = (int'(cell_lvl[c]) * keep) >> 8;
            cell_lvl[c] = (lv < rwft_pkg::LEVEL_FLOOR) ? 9'd0 : 9'(lv);
        end
        cnt = (walkers_q > SLOTS) ? SLOTS : int'(walkers_q);
        for (int w = 0; w < cnt; w++) begin
            t = int'(walk_timer[w]) + int'(move_q);
            if (t >= rwft_pkg::FULL_LEVEL) begin
                walk_timer[w] = '0;
                dir = rwft_pkg::dir_t'(req.directions[2*w +: 2]);
                case (dir)
                    rwft_pkg::DIR_X_INC: begin
                        if (walk_col[w] < COLS - 1) walk_col[w] = walk_col[w] + 3'd1;
                    end
                    rwft_pkg::DIR_X_DEC: begin
                        if (walk_col[w] > 0) walk_col[w] = walk_col[w] - 3'd1;
                    end
                    rwft_pkg::DIR_Y_INC: begin
                        if (walk_row[w] < ROWS - 1) walk_row[w] = walk_row[w] + 3'd1;
                    end
                    default: begin
                        if (walk_row[w] > 0) walk_row[w] = walk_row[w] - 3'd1;
                    end
                endcase
            end else begin
                walk_timer[w] = 9'(t);
            end
        end
        // later walkers overwrite earlier ones on a shared cell
        for (int w = 0; w < cnt; w++) begin
            cell_idx = int'(walk_col[w]) * ROWS + int'(walk_row[w]);
            cell_lvl[cell_idx] = 9'(rwft_pkg::FULL_LEVEL);
            case (w % 5)
                0:       cell_rgb[cell_idx] = 24'hFF0000;
                1:       cell_rgb[cell_idx] = 24'h00FF00;
                2:       cell_rgb[cell_idx] = 24'h0000FF;
                3:       cell_rgb[cell_idx] = 24'hFFFF00;
                default: cell_rgb[cell_idx] = 24'hFF00FF;
            endcase
        end
        for (int x = 0; x < COLS; x++) begin
            for (int y = 0; y < ROWS; y++) begin
                cell_idx = x * ROWS + y;
                lv = int'(cell_lvl[cell_idx]);
                px.pixel_x = 3'(x);
                px.pixel_y = 3'(y);
                px.red     = 8'((int'(cell_rgb[cell_idx][23:16]) * lv) >> 8);
                px.green   = 8'((int'(cell_rgb[cell_idx][15:8]) * lv) >> 8);
                px.blue    = 8'((int'(cell_rgb[cell_idx][7:0]) * lv) >> 8);
                px.last    = (x == COLS - 1) && (y == ROWS - 1);
                pixel_due.push_back(px);
            end
        end
    endtask

    task automatic check_pixel(input rwft_pkg::out_t got);
        rwft_pkg::out_t want;
        if (pixel_due.size() == 0) begin
            flag_mismatch("pixel with none due", int'({got.pixel_x, got.pixel_y}), 0);
            return;
        end
        want = pixel_due.pop_front();
        if (got.pixel_x !== want.pixel_x)
            flag_mismatch("pixel_x", int'(got.pixel_x), int'(want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
            flag_mismatch("pixel_y", int'(got.pixel_y), int'(want.pixel_y));
        if (got.red !== want.red)     flag_mismatch("red", int'(got.red), int'(want.red));
        if (got.green !== want.green) flag_mismatch("green", int'(got.green), int'(want.green));
        if (got.blue !== want.blue)   flag_mismatch("blue", int'(got.blue), int'(want.blue));
        if (got.last !== want.last)   flag_mismatch("last", int'(got.last), int'(want.last));
    endtask

    always @(posedge aclk) begin
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            check_pixel(m_data);
        end
        if (aresetn && s_valid && s_ready) begin
            trail_step(s_data);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= req_backlog.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !(hold_go && !hold_done) && ($urandom_range(99) >= stall_pct);
    end

    initial begin : receiver_hold
        wait (hold_go);
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_done <= 1'b1;
    end

    initial begin : watchdog
        #24_000_000;
        $display("random_walk_fading_trail_top_test: FAIL");
        $finish;
    end

    task automatic queue_frame(input logic [15:0] dirs);
        rwft_pkg::in_t req;
        req = '0;
        req.op = rwft_pkg::OP_FRAME;
        req.directions = dirs;
        req_backlog.push_back(req);
    endtask

    task automatic queue_place(input logic [2:0] w, input logic [2:0] x, input logic [2:0] y);
        rwft_pkg::in_t req;
        req = '0;
        req.op = rwft_pkg::OP_PLACE;
        req.walker_index = w;
        req.place_x = x;
        req.place_y = y;
        req.directions = 16'($urandom);
        req_backlog.push_back(req);
    endtask

    task automatic write_regs(input logic [8:0] fade, input logic [8:0] move,
                              input logic [3:0] walkers);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rwft_pkg::CFG_FADE_RATE;
        cfg_data  <= fade;
        @(negedge aclk);
        cfg_index <= rwft_pkg::CFG_MOVE_RATE;
        cfg_data  <= move;
        @(negedge aclk);
        cfg_index <= rwft_pkg::CFG_ACTIVE_WALKERS;
        cfg_data  <= 9'(walkers);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        fade_q    = fade;
        move_q    = move;
        walkers_q = walkers;
        @(posedge aclk);
        #1;
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || s_valid || pixel_due.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        #1;
    endtask

    initial begin : stimulus
        rwft_pkg::in_t req;
        logic [1:0]    d;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // reset register values and corners; all four directions are sent, but walkers step only on the last frame
        queue_place(3'd0, 3'd7, 3'd7);
        queue_place(3'd7, 3'd0, 3'd0);
        queue_place(3'd3, 3'd3, 3'd4);
        queue_place(3'd1, 3'd7, 3'd0);
        queue_place(3'd2, 3'd0, 3'd7);
        queue_frame(16'h0000);
        queue_frame(16'hFFFF);
        queue_frame(16'h5555);
        queue_frame(16'hAAAA);
        wait_idle();

        // fade and walker count above range, step every frame, clamp at edges
        write_regs(9'd511, 9'd256, 4'd15);
        queue_place(3'd4, 3'd2, 3'd2);
        queue_place(3'd5, 3'd2, 3'd2);
        queue_frame(16'h0000);
        queue_frame(16'h5555);
        queue_frame(16'hAAAA);
        queue_frame(16'hFFFF);
        wait_idle();

        // no fade, no motion, no walkers: the trail must hold still
        write_regs(9'd0, 9'd0, 4'd0);
        queue_frame(16'h1234);
        queue_place(3'd6, 3'd5, 3'd5);
        queue_frame(16'hFFFF);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       write_regs(9'd26, 9'd64, 4'd8);
                1:       write_regs(9'd0, 9'd256, 4'd8);
                2:       write_regs(9'd256, 9'd128, 4'd5);
                3:       write_regs(9'd300, 9'd511, 4'd3);
                default: write_regs(9'($urandom_range(0, 300)), 9'($urandom_range(0, 300)),
                                    4'($urandom_range(0, 15)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            // long receiver hold-off so frames back up behind the output
            if (p == 0) hold_go = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                req.op           = ($urandom_range(99) < 60) ? rwft_pkg::OP_FRAME
                                                             : rwft_pkg::OP_PLACE;
                req.directions   = 16'($urandom);
                req.walker_index = 3'($urandom_range(0, 7));
                req.place_x      = 3'($urandom_range(0, 7));
                req.place_y      = 3'($urandom_range(0, 7));
                if ($urandom_range(99) < 20) begin
                    d = 2'($urandom_range(0, 3));
                    req.directions = {8{d}};
                end
                req_backlog.push_back(req);
            end
            wait_idle();
            if (p == 0) begin
                while (!hold_done) begin
                    @(posedge aclk);
                    #1;
                end
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        if (mismatches == 0) begin
            $display("random_walk_fading_trail_top_test: PASS");
        end else begin
            $display("random_walk_fading_trail_top_test: FAIL");
        end
        $finish;
    end

endmodule
